>>> sv/nsq_pkg.sv
// package: shared types, constants and helpers for the nine-slice quad generator
`timescale 1ns / 1ps
package nsq_pkg;

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [2:0] REG_MARGIN_LEFT   = 3'd0;
    localparam logic [2:0] REG_MARGIN_TOP    = 3'd1;
    localparam logic [2:0] REG_MARGIN_RIGHT  = 3'd2;
    localparam logic [2:0] REG_MARGIN_BOTTOM = 3'd3;
    localparam logic [2:0] REG_TEX_WIDTH     = 3'd4;
    localparam logic [2:0] REG_TEX_HEIGHT    = 3'd5;
    localparam logic [2:0] REG_FILL_COLOR    = 3'd6;

    // slicing mode chosen by the front end
    typedef enum logic [1:0] {
        MODE_ONE  = 2'd0,
        MODE_HOR  = 2'd1,
        MODE_VER  = 2'd2,
        MODE_NINE = 2'd3
    } mode_t;

    // back end state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_GEOM = 2'd1,
        ST_MUL  = 2'd2,
        ST_DIV  = 2'd3
    } state_t;

    // classified request held in the queue
    typedef struct packed {
        mode_t              mode;
        logic signed [19:0] rx;
        logic signed [19:0] ry;
        logic signed [19:0] rw;
        logic signed [19:0] rh;
        logic [14:0]        sx;
        logic [14:0]        sy;
        logic [14:0]        sw;
        logic [14:0]        sh;
        logic [11:0]        el;
        logic [11:0]        et;
        logic [11:0]        er;
        logic [11:0]        eb;
    } job_t;

    // one result quad
    typedef struct packed {
        logic signed [16:0] dst_left;
        logic signed [16:0] dst_top;
        logic signed [16:0] dst_right;
        logic signed [16:0] dst_bottom;
        logic [16:0]        u_left;
        logic [16:0]        v_top;
        logic [16:0]        u_right;
        logic [16:0]        v_bottom;
        logic [31:0]        quad_color;
        logic [3:0]         piece_index;
        logic               last_piece;
    } quad_t;

    // clamp to the 17-bit signed corner range
    function automatic logic signed [16:0] pos17(input logic signed [19:0] v);
        logic signed [16:0] r;
        if (v < -20'sd65536) begin
            r = -17'sd65536;
        end else if (v > 20'sd65535) begin
            r = 17'sd65535;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

>>> sv/nsq_front.sv
// front end: margin shrink, empty test and mode selection
`timescale 1ns / 1ps
module nsq_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          area_x,
    input  logic [15:0]          area_y,
    input  logic [14:0]          area_w,
    input  logic [14:0]          area_h,
    input  logic [14:0]          src_x,
    input  logic [14:0]          src_y,
    input  logic [14:0]          src_w,
    input  logic [14:0]          src_h,
    input  logic [11:0]          edge_left,
    input  logic [11:0]          edge_top,
    input  logic [11:0]          edge_right,
    input  logic [11:0]          edge_bottom,
    input  logic [11:0]          margin_left,
    input  logic [11:0]          margin_top,
    input  logic [11:0]          margin_right,
    input  logic [11:0]          margin_bottom,
    output logic                 job_valid,
    input  logic                 job_ready,
    output nsq_pkg::job_t        job
);
    logic signed [19:0] rx, ry, rw, rh;
    logic               hor, ver, empty;
    nsq_pkg::job_t      queue_reg [nsq_pkg::QUEUE_DEPTH];
    logic [1:0]         count_reg, count_next;
    logic               wr_ptr_reg, rd_ptr_reg;
    logic               push, pop;

    // shrink the area
    always_comb begin
        rx = 20'(signed'(area_x)) + 20'(margin_left);
        ry = 20'(signed'(area_y)) + 20'(margin_top);
        rw = 20'(area_w) - 20'(margin_left) - 20'(margin_right);
        rh = 20'(area_h) - 20'(margin_top) - 20'(margin_bottom);
        empty = (rw <= 20'sd0) || (rh <= 20'sd0);
        hor = (rw > 20'(src_w)) && ((edge_left != 12'd0) || (edge_right != 12'd0));
        ver = (rh > 20'(src_h)) && ((edge_top != 12'd0) || (edge_bottom != 12'd0));
    end

    assign in_ready  = (count_reg != 2'(nsq_pkg::QUEUE_DEPTH));
    assign push      = in_valid && in_ready && !empty;
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = queue_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    // queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg].mode <= hor ? (ver ? nsq_pkg::MODE_NINE : nsq_pkg::MODE_HOR)
                                              : (ver ? nsq_pkg::MODE_VER : nsq_pkg::MODE_ONE);
            queue_reg[wr_ptr_reg].rx <= rx;
            queue_reg[wr_ptr_reg].ry <= ry;
            queue_reg[wr_ptr_reg].rw <= rw;
            queue_reg[wr_ptr_reg].rh <= rh;
            queue_reg[wr_ptr_reg].sx <= src_x;
            queue_reg[wr_ptr_reg].sy <= src_y;
            queue_reg[wr_ptr_reg].sw <= src_w;
            queue_reg[wr_ptr_reg].sh <= src_h;
            queue_reg[wr_ptr_reg].el <= edge_left;
            queue_reg[wr_ptr_reg].et <= edge_top;
            queue_reg[wr_ptr_reg].er <= edge_right;
            queue_reg[wr_ptr_reg].eb <= edge_bottom;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end
endmodule

>>> sv/nsq_div.sv
// iterative divider: floor(num / den) saturated to 17 bits, one quotient bit per cycle
`timescale 1ns / 1ps
module nsq_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [14:0] den,
    output logic        busy,
    output logic [16:0] quot
);
    logic [31:0] num_reg;
    logic [15:0] rem_reg;
    logic [14:0] den_reg;
    logic [16:0] q_reg;
    logic [5:0]  cnt_reg;
    logic        sat_reg;
    logic [16:0] rem_shift;
    logic        ge;

    assign rem_shift = {rem_reg, num_reg[31]};
    assign ge        = rem_shift >= 17'(den_reg);
    assign busy      = (cnt_reg != 6'd0);
    assign quot      = sat_reg ? 17'h1FFFF : q_reg;

    // restoring division over 32 numerator bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (start) begin
            cnt_reg <= 6'd32;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= (den == 15'd0) ? 15'd1 : den;
            rem_reg <= 16'd0;
            q_reg   <= 17'd0;
            sat_reg <= 1'b0;
        end else if (busy) begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= ge ? 16'(rem_shift - 17'(den_reg)) : rem_shift[15:0];
            q_reg   <= {q_reg[15:0], ge};
            if (q_reg[16]) begin
                sat_reg <= 1'b1;
            end
        end
    end
endmodule

>>> sv/nsq_back.sv
// back end: walks the pieces of one job and forms each quad
`timescale 1ns / 1ps
module nsq_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  nsq_pkg::job_t        job,
    input  logic [14:0]          tex_width,
    input  logic [14:0]          tex_height,
    input  logic [31:0]          fill_color,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nsq_pkg::quad_t       quad
);
    nsq_pkg::state_t    state_reg, state_next;
    nsq_pkg::job_t      job_reg;
    logic [3:0]         piece_reg, piece_next;
    logic [3:0]         count;
    logic signed [19:0] dx, dy, dw, dh, sxx, syy, sww, shh;
    logic signed [19:0] w, h, scw, sch, sxr, syb, dxr, dyb, lenx, leny;
    logic signed [19:0] rx, ry, el, et, er, eb, sx, sy, sw, sh;
    logic signed [19:0] t_reg [4];
    logic [31:0]        num [4];
    logic [3:0]         start, busy;
    logic [16:0]        qt [4];
    logic               out_valid_reg;
    nsq_pkg::quad_t     quad_reg;
    logic signed [16:0] dl_reg, dt_reg, dr_reg, db_reg;
    logic [31:0]        color_reg;
    logic [3:0]         index_reg;
    logic               last_reg;
    logic               load;

    assign rx = job_reg.rx;
    assign ry = job_reg.ry;
    assign el = 20'(job_reg.el);
    assign et = 20'(job_reg.et);
    assign er = 20'(job_reg.er);
    assign eb = 20'(job_reg.eb);
    assign sx = 20'(job_reg.sx);
    assign sy = 20'(job_reg.sy);
    assign sw = 20'(job_reg.sw);
    assign sh = 20'(job_reg.sh);

    // shared piece terms
    always_comb begin
        w    = job_reg.rw - (el + er);
        h    = job_reg.rh - (et + eb);
        scw  = sw - (el + er);
        sch  = sh - (et + eb);
        sxr  = sx + sw - er;
        syb  = sy + sh - eb;
        dxr  = rx + el + w;
        dyb  = ry + et + h;
        lenx = w;
        leny = h;
    end

    // piece geometry table
    always_comb begin
        dx = rx; dy = ry; dw = job_reg.rw; dh = job_reg.rh;
        sxx = sx; syy = sy; sww = sw; shh = sh;
        count = 4'd1;
        case (job_reg.mode)
            nsq_pkg::MODE_NINE: begin
                count = 4'd9;
                case (piece_reg)
                    4'd0: begin dx = rx + el; dy = ry + et; dw = w; dh = h;
                        sxx = sx + el; syy = sy + et; sww = scw; shh = sch; end
                    4'd1: begin dx = rx; dy = ry + et; dw = el; dh = h;
                        sxx = sx; syy = sy + et; sww = el; shh = sch; end
                    4'd2: begin dx = dxr; dy = ry + et; dw = er; dh = h;
                        sxx = sxr; syy = sy + et; sww = er; shh = sch; end
                    4'd3: begin dx = rx + el; dy = dyb; dw = w; dh = eb;
                        sxx = sx + el; syy = syb; sww = scw; shh = eb; end
                    4'd4: begin dx = rx + el; dy = ry; dw = w; dh = et;
                        sxx = sx + el; syy = sy; sww = scw; shh = et; end
                    4'd5: begin dx = rx; dy = ry; dw = el; dh = et;
                        sxx = sx; syy = sy; sww = el; shh = et; end
                    4'd6: begin dx = dxr; dy = ry; dw = er; dh = et;
                        sxx = sxr; syy = sy; sww = er; shh = et; end
                    4'd7: begin dx = rx; dy = dyb; dw = el; dh = eb;
                        sxx = sx; syy = syb; sww = el; shh = eb; end
                    default: begin dx = dxr; dy = dyb; dw = er; dh = eb;
                        sxx = sxr; syy = syb; sww = er; shh = eb; end
                endcase
            end
            nsq_pkg::MODE_HOR: begin
                count = 4'd3;
                case (piece_reg)
                    4'd0: begin dw = el; sww = el; end
                    4'd1: begin dx = rx + el; dw = lenx; sxx = sx + el; sww = scw; end
                    default: begin dx = rx + el + lenx; dw = er; sxx = sxr; sww = er; end
                endcase
            end
            nsq_pkg::MODE_VER: begin
                count = 4'd3;
                case (piece_reg)
                    4'd0: begin dh = et; shh = et; end
                    4'd1: begin dy = ry + et; dh = leny; syy = sy + et; shh = sch; end
                    default: begin dy = ry + et + leny; dh = eb; syy = syb; shh = eb; end
                endcase
            end
            default: begin
                count = 4'd1;
            end
        endcase
    end

    // numerators: texel scaled by 65536, zero for texels at or below zero
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = (t_reg[i] <= 20'sd0) ? 32'd0 : {t_reg[i][15:0], 16'd0};
        end
    end

    // four coordinate dividers
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_div
            nsq_div u_div (
                .aclk   (aclk),
                .aresetn(aresetn),
                .start  (start[g]),
                .num    (num[g]),
                .den    ((g == 0 || g == 2) ? tex_width : tex_height),
                .busy   (busy[g]),
                .quot   (qt[g])
            );
        end
    endgenerate

    assign load      = !out_valid_reg || out_ready;
    assign job_ready = (state_reg == nsq_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign quad      = quad_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        piece_next = piece_reg;
        start      = 4'b0000;
        case (state_reg)
            nsq_pkg::ST_IDLE: begin
                if (job_valid) begin
                    state_next = nsq_pkg::ST_GEOM;
                    piece_next = 4'd0;
                end
            end
            nsq_pkg::ST_GEOM: begin
                state_next = nsq_pkg::ST_MUL;
            end
            nsq_pkg::ST_MUL: begin
                start      = 4'b1111;
                state_next = nsq_pkg::ST_DIV;
            end
            nsq_pkg::ST_DIV: begin
                if (busy == 4'b0000 && load) begin
                    if (piece_reg == count - 4'd1) begin
                        state_next = nsq_pkg::ST_IDLE;
                    end else begin
                        piece_next = piece_reg + 4'd1;
                        state_next = nsq_pkg::ST_GEOM;
                    end
                end
            end
            default: begin
                state_next = nsq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nsq_pkg::ST_IDLE;
            piece_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            piece_reg <= piece_next;
            if (state_reg == nsq_pkg::ST_DIV && busy == 4'b0000 && load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job, texel terms, staged corners and quad payload
    always_ff @(posedge aclk) begin
        if (state_reg == nsq_pkg::ST_IDLE && job_valid) begin
            job_reg <= job;
        end
        if (state_reg == nsq_pkg::ST_GEOM) begin
            t_reg[0]  <= sxx;
            t_reg[1]  <= syy;
            t_reg[2]  <= sxx + sww;
            t_reg[3]  <= syy + shh;
            dl_reg    <= nsq_pkg::pos17(dx);
            dt_reg    <= nsq_pkg::pos17(dy);
            dr_reg    <= nsq_pkg::pos17(dx + dw);
            db_reg    <= nsq_pkg::pos17(dy + dh);
            color_reg <= fill_color;
            index_reg <= piece_reg;
            last_reg  <= (piece_reg == count - 4'd1);
        end
        if (state_reg == nsq_pkg::ST_DIV && busy == 4'b0000 && load) begin
            quad_reg.dst_left    <= dl_reg;
            quad_reg.dst_top     <= dt_reg;
            quad_reg.dst_right   <= dr_reg;
            quad_reg.dst_bottom  <= db_reg;
            quad_reg.u_left      <= qt[0];
            quad_reg.v_top       <= qt[1];
            quad_reg.u_right     <= qt[2];
            quad_reg.v_bottom    <= qt[3];
            quad_reg.quad_color  <= color_reg;
            quad_reg.piece_index <= index_reg;
            quad_reg.last_piece  <= last_reg;
        end
    end
endmodule

>>> sv/nine_slice_quad_generator.sv
// top level: nine-slice quad generator with config port, front end and back end
//
//  channel  | dir | handshake          | payload
//  s_axis   | in  | s_tvalid/s_tready  | s_tdata: draw request
//  m_axis   | out | m_tvalid/m_tready  | m_tdata quad, m_tlast last piece
//  cfg      | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// each quad passes through geometry, divider start and the 32-step dividers
// a request with n quads occupies the back end for n such slots plus a pass through the idle state
// a two-entry queue lets the front end take new requests while quads are formed
// a held quad stalls the back end only when the next quad is ready to replace it
// synchronous active-low reset clears control state and the register defaults
`timescale 1ns / 1ps
module nine_slice_quad_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // area_x, area_y, area_w, area_h, src_x, src_y, src_w, src_h,
    // edge_left, edge_top, edge_right, edge_bottom
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dst_left, dst_top, dst_right, dst_bottom, u_left, v_top, u_right,
    // v_bottom, quad_color, piece_index
    output logic [175:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [11:0]    ml_reg, mt_reg, mr_reg, mb_reg;
    logic [14:0]    tw_reg, th_reg;
    logic [31:0]    color_reg;
    logic           job_valid, job_ready;
    nsq_pkg::job_t  job;
    nsq_pkg::quad_t quad;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ml_reg <= 12'd0; mt_reg <= 12'd0; mr_reg <= 12'd0; mb_reg <= 12'd0;
            tw_reg <= 15'd1; th_reg <= 15'd1; color_reg <= 32'hFFFFFFFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                nsq_pkg::REG_MARGIN_LEFT:   ml_reg <= cfg_data[11:0];
                nsq_pkg::REG_MARGIN_TOP:    mt_reg <= cfg_data[11:0];
                nsq_pkg::REG_MARGIN_RIGHT:  mr_reg <= cfg_data[11:0];
                nsq_pkg::REG_MARGIN_BOTTOM: mb_reg <= cfg_data[11:0];
                nsq_pkg::REG_TEX_WIDTH:     tw_reg <= cfg_data[14:0];
                nsq_pkg::REG_TEX_HEIGHT:    th_reg <= cfg_data[14:0];
                nsq_pkg::REG_FILL_COLOR:    color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nsq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .area_x(s_tdata[15:0]), .area_y(s_tdata[31:16]),
        .area_w(s_tdata[46:32]), .area_h(s_tdata[61:47]),
        .src_x(s_tdata[76:62]), .src_y(s_tdata[91:77]),
        .src_w(s_tdata[106:92]), .src_h(s_tdata[121:107]),
        .edge_left(s_tdata[133:122]), .edge_top(s_tdata[145:134]),
        .edge_right(s_tdata[157:146]), .edge_bottom(s_tdata[169:158]),
        .margin_left(ml_reg), .margin_top(mt_reg),
        .margin_right(mr_reg), .margin_bottom(mb_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    nsq_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .tex_width(tw_reg), .tex_height(th_reg), .fill_color(color_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .quad(quad)
    );

    // pack the quad
    assign m_tdata = {4'd0, quad.piece_index, quad.quad_color,
                      quad.v_bottom, quad.u_right, quad.v_top, quad.u_left,
                      quad.dst_bottom, quad.dst_right, quad.dst_top, quad.dst_left};
    assign m_tlast = quad.last_piece;

    // checks
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[171:168] <= 4'd8)) else $error("piece index out of range");
    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[171:168] == 4'd0 || m_tdata[171:168] == 4'd2
        || m_tdata[171:168] == 4'd8)) else $error("bad final piece index");
endmodule

>>> dv/tb.sv
// testbench for the nine-slice quad generator: stream driver, monitor and quad predictor
`timescale 1ns / 1ps
module tb;

    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_STALL = 1500;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [14:0] aw;
        logic [14:0] ah;
        logic [14:0] sx;
        logic [14:0] sy;
        logic [14:0] sw;
        logic [14:0] sh;
        logic [11:0] el;
        logic [11:0] et;
        logic [11:0] er;
        logic [11:0] eb;
    } draw_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [175:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = nsq_pkg::REG_MARGIN_LEFT;
    logic [31:0] cfg_data = '0;

    // predictor copy of the registers
    longint mgn_l = 0, mgn_t = 0, mgn_r = 0, mgn_b = 0;
    longint tex_w = 1, tex_h = 1;
    logic [31:0] color = 32'hFFFF_FFFF;

    draw_req_t pending_reqs[$];
    draw_req_t cur_req;
    nsq_pkg::quad_t expected_quads[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic stall_go = 1'b0;
    int stall_cnt = 0;
    int quiet_cycles = 0;

    nine_slice_quad_generator dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [16:0] clamp_pos(longint v);
        if (v < -65536) v = -65536;
        if (v > 65535) v = 65535;
        return v[16:0];
    endfunction

    function automatic logic [16:0] tex_coord(longint texel, longint size);
        longint d, q;
        d = (size == 0) ? 1 : size;
        if (texel <= 0) return '0;
        q = (texel * 65536) / d;
        if (q > 131071) q = 131071;
        return q[16:0];
    endfunction

    function automatic void add_quad(int k, longint dx, longint dy, longint dw, longint dh,
                                     longint sx, longint sy, longint sw, longint sh);
        nsq_pkg::quad_t q;
        q.dst_left = clamp_pos(dx);
        q.dst_top = clamp_pos(dy);
        q.dst_right = clamp_pos(dx + dw);
        q.dst_bottom = clamp_pos(dy + dh);
        q.u_left = tex_coord(sx, tex_w);
        q.v_top = tex_coord(sy, tex_h);
        q.u_right = tex_coord(sx + sw, tex_w);
        q.v_bottom = tex_coord(sy + sh, tex_h);
        q.quad_color = color;
        q.piece_index = k[3:0];
        q.last_piece = 1'b0;
        expected_quads.push_back(q);
    endfunction

    // slice one request into its expected quads
    function automatic void predict_quads(draw_req_t r);
        longint rx, ry, rw, rh, sx, sy, sw, sh, el, et, er, eb;
        longint w, h, scw, sch, sxr, syb, dxr, dyb;
        bit hor, ver;
        rx = longint'(r.ax) + mgn_l;
        ry = longint'(r.ay) + mgn_t;
        rw = longint'(r.aw) - (mgn_l + mgn_r);
        rh = longint'(r.ah) - (mgn_t + mgn_b);
        sx = longint'(r.sx); sy = longint'(r.sy); sw = longint'(r.sw); sh = longint'(r.sh);
        el = longint'(r.el); et = longint'(r.et); er = longint'(r.er); eb = longint'(r.eb);
        if (rw <= 0 || rh <= 0) return;
        hor = (rw > sw) && (el != 0 || er != 0);
        ver = (rh > sh) && (et != 0 || eb != 0);
        if (hor && ver) begin
            w = rw - (el + er); h = rh - (et + eb);
            scw = sw - (el + er); sch = sh - (et + eb);
            sxr = sx + sw - er; syb = sy + sh - eb;
            dxr = rx + el + w; dyb = ry + et + h;
            add_quad(0, rx + el, ry + et, w, h, sx + el, sy + et, scw, sch);
            add_quad(1, rx, ry + et, el, h, sx, sy + et, el, sch);
            add_quad(2, dxr, ry + et, er, h, sxr, sy + et, er, sch);
            add_quad(3, rx + el, dyb, w, eb, sx + el, syb, scw, eb);
            add_quad(4, rx + el, ry, w, et, sx + el, sy, scw, et);
            add_quad(5, rx, ry, el, et, sx, sy, el, et);
            add_quad(6, dxr, ry, er, et, sxr, sy, er, et);
            add_quad(7, rx, dyb, el, eb, sx, syb, el, eb);
            add_quad(8, dxr, dyb, er, eb, sxr, syb, er, eb);
        end else if (hor) begin
            w = rw - (el + er);
            add_quad(0, rx, ry, el, rh, sx, sy, el, sh);
            add_quad(1, rx + el, ry, w, rh, sx + el, sy, sw - (el + er), sh);
            add_quad(2, rx + el + w, ry, er, rh, sx + sw - er, sy, er, sh);
        end else if (ver) begin
            h = rh - (et + eb);
            add_quad(0, rx, ry, rw, et, sx, sy, sw, et);
            add_quad(1, rx, ry + et, rw, h, sx, sy + et, sw, sh - (et + eb));
            add_quad(2, rx, ry + et + h, rw, eb, sx, sy + sh - eb, sw, eb);
        end else begin
            add_quad(0, rx, ry, rw, rh, sx, sy, sw, sh);
        end
        expected_quads[$].last_piece = 1'b1;
    endfunction

    function automatic draw_req_t mk_req(int ax, int ay, int aw, int ah, int sx, int sy,
                                         int sw, int sh, int el, int et, int er, int eb);
        draw_req_t r;
        r.ax = 16'(ax); r.ay = 16'(ay); r.aw = 15'(aw); r.ah = 15'(ah);
        r.sx = 15'(sx); r.sy = 15'(sy); r.sw = 15'(sw); r.sh = 15'(sh);
        r.el = 12'(el); r.et = 12'(et); r.er = 12'(er); r.eb = 12'(eb);
        return r;
    endfunction

    // mostly sliceable requests, some full-range noise
    function automatic draw_req_t rand_req();
        draw_req_t r;
        if ($urandom_range(3) == 0) begin
            r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            r.sw = 15'($urandom_range(200));
            r.sh = 15'($urandom_range(200));
            r.sx = 15'($urandom_range(16384 - 200));
            r.sy = 15'($urandom_range(16384 - 200));
            r.el = ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom_range(60));
            r.er = ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom_range(60));
            r.et = ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom_range(60));
            r.eb = ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom_range(60));
            r.aw = 15'($urandom_range(600));
            r.ah = 15'($urandom_range(600));
            r.ax = 16'($urandom_range(4000) - 2000);
            r.ay = 16'($urandom_range(4000) - 2000);
        end
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_quads(cur_req);
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, cur_req.eb, cur_req.er, cur_req.et, cur_req.el,
                                cur_req.sh, cur_req.sw, cur_req.sy, cur_req.sx,
                                cur_req.ah, cur_req.aw, cur_req.ay, cur_req.ax};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // quad monitor and receiver stalls
    always @(posedge aclk) begin
        nsq_pkg::quad_t got, exp_q;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.dst_left    = m_tdata[16:0];
                got.dst_top     = m_tdata[33:17];
                got.dst_right   = m_tdata[50:34];
                got.dst_bottom  = m_tdata[67:51];
                got.u_left      = m_tdata[84:68];
                got.v_top       = m_tdata[101:85];
                got.u_right     = m_tdata[118:102];
                got.v_bottom    = m_tdata[135:119];
                got.quad_color  = m_tdata[167:136];
                got.piece_index = m_tdata[171:168];
                got.last_piece  = m_tlast;
                if (expected_quads.size() == 0) begin
                    $error("quad received with none expected");
                    errors++;
                end else begin
                    exp_q = expected_quads.pop_front();
                    if (got.dst_left !== exp_q.dst_left) begin
                        $error("dst_left exp %0d got %0d", exp_q.dst_left, got.dst_left); errors++;
                    end
                    if (got.dst_top !== exp_q.dst_top) begin
                        $error("dst_top exp %0d got %0d", exp_q.dst_top, got.dst_top); errors++;
                    end
                    if (got.dst_right !== exp_q.dst_right) begin
                        $error("dst_right exp %0d got %0d", exp_q.dst_right, got.dst_right);
                        errors++;
                    end
                    if (got.dst_bottom !== exp_q.dst_bottom) begin
                        $error("dst_bottom exp %0d got %0d", exp_q.dst_bottom, got.dst_bottom);
                        errors++;
                    end
                    if (got.u_left !== exp_q.u_left) begin
                        $error("u_left exp %0d got %0d", exp_q.u_left, got.u_left); errors++;
                    end
                    if (got.v_top !== exp_q.v_top) begin
                        $error("v_top exp %0d got %0d", exp_q.v_top, got.v_top); errors++;
                    end
                    if (got.u_right !== exp_q.u_right) begin
                        $error("u_right exp %0d got %0d", exp_q.u_right, got.u_right); errors++;
                    end
                    if (got.v_bottom !== exp_q.v_bottom) begin
                        $error("v_bottom exp %0d got %0d", exp_q.v_bottom, got.v_bottom); errors++;
                    end
                    if (got.quad_color !== exp_q.quad_color) begin
                        $error("quad_color exp %h got %h", exp_q.quad_color, got.quad_color);
                        errors++;
                    end
                    if (got.piece_index !== exp_q.piece_index) begin
                        $error("piece_index exp %0d got %0d", exp_q.piece_index, got.piece_index);
                        errors++;
                    end
                    if (got.last_piece !== exp_q.last_piece) begin
                        $error("last_piece exp %0d got %0d", exp_q.last_piece, got.last_piece);
                        errors++;
                    end
                end
            end
            if (stall_go) begin
                stall_cnt <= LONG_STALL;
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            nsq_pkg::REG_MARGIN_LEFT:   mgn_l = longint'(val[11:0]);
            nsq_pkg::REG_MARGIN_TOP:    mgn_t = longint'(val[11:0]);
            nsq_pkg::REG_MARGIN_RIGHT:  mgn_r = longint'(val[11:0]);
            nsq_pkg::REG_MARGIN_BOTTOM: mgn_b = longint'(val[11:0]);
            nsq_pkg::REG_TEX_WIDTH:     tex_w = longint'(val[14:0]);
            nsq_pkg::REG_TEX_HEIGHT:    tex_h = longint'(val[14:0]);
            nsq_pkg::REG_FILL_COLOR:    color = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int ml, int mt, int mr, int mb, int tw, int th, logic [31:0] c);
        write_reg(nsq_pkg::REG_MARGIN_LEFT, ml);
        write_reg(nsq_pkg::REG_MARGIN_TOP, mt);
        write_reg(nsq_pkg::REG_MARGIN_RIGHT, mr);
        write_reg(nsq_pkg::REG_MARGIN_BOTTOM, mb);
        write_reg(nsq_pkg::REG_TEX_WIDTH, tw);
        write_reg(nsq_pkg::REG_TEX_HEIGHT, th);
        write_reg(nsq_pkg::REG_FILL_COLOR, c);
    endtask

    // wait for every queued request and quad, then let empty requests flush
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_quads.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests on reset register values
        pending_reqs.push_back(mk_req(0, 0, 0, 10, 0, 0, 4, 4, 1, 1, 1, 1));
        pending_reqs.push_back(mk_req(5, 5, 10, 0, 0, 0, 4, 4, 1, 1, 1, 1));
        pending_reqs.push_back(mk_req(3, 4, 20, 20, 0, 0, 30, 30, 0, 0, 0, 0));
        drain();
        set_regs(2, 3, 1, 4, 256, 128, 32'h1234_5678);
        pending_reqs.push_back(mk_req(10, 20, 40, 40, 8, 8, 64, 64, 4, 4, 4, 4));
        pending_reqs.push_back(mk_req(10, 20, 100, 40, 8, 8, 32, 64, 4, 0, 6, 0));
        pending_reqs.push_back(mk_req(-10, -20, 40, 100, 8, 8, 64, 32, 0, 5, 0, 7));
        pending_reqs.push_back(mk_req(0, 0, 100, 100, 16, 16, 32, 32, 6, 5, 4, 3));
        pending_reqs.push_back(mk_req(-32768, -32768, 32767, 32767, 0, 0, 16384, 16384,
                                      4095, 4095, 4095, 4095));
        pending_reqs.push_back(mk_req(32767, 32767, 32767, 32767, 16384, 16384, 16384,
                                      16384, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(0, 0, 500, 500, 0, 0, 10, 10, 4095, 4095, 4095, 4095));
        pending_reqs.push_back(mk_req(-32768, 32767, 32767, 100, 0, 0, 0, 0, 1, 0, 0, 0));
        pending_reqs.push_back(mk_req(100, 100, 3, 300, 2, 2, 2, 2, 0, 0, 0, 4095));
        pending_reqs.push_back(mk_req(0, 0, 10, 10, 0, 0, 10, 10, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(0, 0, 5, 5, 0, 0, 10, 10, 0, 0, 0, 0));
        drain();
        // zero texture size, maximal margins
        set_regs(4095, 4095, 4095, 4095, 0, 0, 32'h0);
        pending_reqs.push_back(mk_req(0, 0, 10000, 10000, 3, 3, 5, 5, 1, 1, 1, 1));
        pending_reqs.push_back(mk_req(0, 0, 8190, 9000, 3, 3, 5, 5, 1, 1, 1, 1));
        pending_reqs.push_back(mk_req(32767, -32768, 32767, 32767, 100, 100, 50, 50,
                                      2, 2, 2, 2));
        drain();

        // random phases over the idling modes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == 0) set_regs(0, 0, 0, 0, 16384, 16384, 32'hFFFF_FFFF);
            else if (ph == 1) set_regs(0, 0, 0, 0, 1, 1, 32'hA5A5_5A5A);
            else set_regs($urandom_range(40), $urandom_range(40), $urandom_range(40),
                          $urandom_range(40), $urandom_range(16384, 1),
                          $urandom_range(16384, 1), $urandom);
            for (int i = 0; i < 50; i++) pending_reqs.push_back(rand_req());
            if (ph == 2) begin
                @(posedge aclk);
                stall_go <= 1'b1;
                @(posedge aclk);
                stall_go <= 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
sv/nsq_pkg.sv
sv/nsq_front.sv
sv/nsq_div.sv
sv/nsq_back.sv
sv/nine_slice_quad_generator.sv
dv/tb.sv
